/* sv/pbr_pkg.sv */
// pbr_pkg: shared types, constants and lookup tables for the pixel brightness rescale block
// no dependencies; used by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package pbr_pkg;

  localparam int unsigned CH_W   = 8;   // color channel width
  localparam int unsigned PCT_W  = 7;   // percent value width
  localparam int unsigned HUE_W  = 9;   // hue in degrees
  localparam int unsigned PCT_FULL = 100;
  localparam int unsigned CIRCLE_DEG = 360;

  // divider operand widths
  localparam int unsigned NUM_W = 18;
  localparam int unsigned DEN_W = 9;
  localparam int unsigned QUO_W = 9;

  // hue sectors of 60 degrees
  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_t;

  typedef logic [PCT_W-1:0] vold_lut_t [256];
  typedef logic [CH_W-1:0]  top_lut_t  [128];

  // rounded value percent for each max channel code
  function automatic vold_lut_t build_vold_lut();
    vold_lut_t lut;
    for (int i = 0; i < 256; i++) begin
      lut[i] = PCT_W'((200 * i + 255) / 510);
    end
    return lut;
  endfunction

  // full-scale channel code for each brightness percent, saturated at 100
  function automatic top_lut_t build_top_lut();
    top_lut_t lut;
    int lv;
    for (int i = 0; i < 128; i++) begin
      lv = (i > 100) ? 100 : i;
      lut[i] = CH_W'((lv * 255) / 100);
    end
    return lut;
  endfunction

endpackage

`default_nettype wire

/* sv/pbr_if.sv */
// pbr_in_if / pbr_out_if: valid-ready channels for pixels in and results out
// depends on pbr_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface pbr_in_if import pbr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CH_W-1:0]  red_in;
  logic [CH_W-1:0]  green_in;
  logic [CH_W-1:0]  blue_in;
  logic [PCT_W-1:0] new_level;

  modport source (output valid, red_in, green_in, blue_in, new_level, input ready);
  modport sink   (input valid, red_in, green_in, blue_in, new_level, output ready);
endinterface

interface pbr_out_if import pbr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CH_W-1:0]  red_out;
  logic [CH_W-1:0]  green_out;
  logic [CH_W-1:0]  blue_out;
  logic [HUE_W-1:0] hue_deg;
  logic [PCT_W-1:0] sat_pct;
  logic [PCT_W-1:0] old_level;

  modport source (output valid, red_out, green_out, blue_out, hue_deg, sat_pct, old_level,
                  input ready);
  modport sink   (input valid, red_out, green_out, blue_out, hue_deg, sat_pct, old_level,
                  output ready);
endinterface

`default_nettype wire

/* sv/pbr_front.sv */
// pbr_front: max/min search, value lookup and divider operands for hue and saturation
// depends on pbr_pkg
`timescale 1ns / 1ps
`default_nettype none

module pbr_front import pbr_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire logic             vld_in,
  input  wire logic [CH_W-1:0]  red,
  input  wire logic [CH_W-1:0]  green,
  input  wire logic [CH_W-1:0]  blue,
  input  wire logic [PCT_W-1:0] level,
  output logic                  vld,
  output logic [NUM_W-1:0]      sat_num,
  output logic [DEN_W-1:0]      sat_den,
  output logic [NUM_W-1:0]      hue_num,
  output logic [DEN_W-1:0]      hue_den,
  output logic [PCT_W-1:0]      vold,
  output logic [PCT_W-1:0]      lvl
);

  localparam vold_lut_t VOLD_LUT = build_vold_lut();

  logic [CH_W-1:0]  mx, mn, d;
  logic [NUM_W-1:0] r18, g18, b18, d18;
  logic [NUM_W-1:0] hue_num_next;

  // channel extremes
  always_comb begin
    mx = red;
    if (green > mx) mx = green;
    if (blue > mx) mx = blue;
    mn = red;
    if (green < mn) mn = green;
    if (blue < mn) mn = blue;
    d = mx - mn;
  end

  assign r18 = NUM_W'(red);
  assign g18 = NUM_W'(green);
  assign b18 = NUM_W'(blue);
  assign d18 = NUM_W'(d);

  // hue numerator per sector, offset so it stays non-negative; red wins ties
  always_comb begin
    if (d == '0) begin
      hue_num_next = '0;
    end else if (red == mx) begin
      hue_num_next = NUM_W'(120) * g18 + NUM_W'(721) * d18 - NUM_W'(120) * b18;
    end else if (green == mx) begin
      hue_num_next = NUM_W'(120) * b18 + NUM_W'(241) * d18 - NUM_W'(120) * r18;
    end else begin
      hue_num_next = NUM_W'(120) * r18 + NUM_W'(481) * d18 - NUM_W'(120) * g18;
    end
  end

  // operand register
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (en) begin
      vld <= vld_in;
    end
    if (en) begin
      sat_num <= NUM_W'(200) * d18 + NUM_W'(mx);
      sat_den <= (mx == '0) ? DEN_W'(1) : {mx, 1'b0};
      hue_num <= hue_num_next;
      hue_den <= (d == '0) ? DEN_W'(1) : {d, 1'b0};
      vold    <= VOLD_LUT[mx];
      lvl     <= (level > PCT_W'(PCT_FULL)) ? PCT_W'(PCT_FULL) : level;
    end
  end

endmodule

`default_nettype wire

/* sv/pbr_div.sv */
// pbr_div: pipelined restoring divider, one quotient bit per stage, side data alongside
// depends on pbr_pkg only through the importing convention
`timescale 1ns / 1ps
`default_nettype none

module pbr_div import pbr_pkg::*; #(
  parameter int unsigned N_W    = 18,
  parameter int unsigned D_W    = 9,
  parameter int unsigned Q_W    = 9,
  parameter int unsigned SIDE_W = 7
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              vld_in,
  input  wire logic [N_W-1:0]    num,
  input  wire logic [D_W-1:0]    den,
  input  wire logic [SIDE_W-1:0] side_in,
  output logic                   vld_out,
  output logic [Q_W-1:0]         quo,
  output logic [SIDE_W-1:0]      side_out
);

  localparam int unsigned W = (N_W > D_W + Q_W) ? N_W : D_W + Q_W;

  logic              vld    [Q_W];
  logic [W-1:0]      rem    [Q_W-1];
  logic [Q_W-1:0]    quo_r  [Q_W];
  logic [D_W-1:0]    den_r  [Q_W];
  logic [SIDE_W-1:0] side_r [Q_W];

  for (genvar s = 0; s < Q_W; s++) begin : g_step
    localparam int unsigned K = Q_W - 1 - s;
    logic              vld_prev;
    logic [W-1:0]      rem_prev, shifted, rem_next;
    logic [Q_W-1:0]    quo_prev;
    logic [D_W-1:0]    den_prev;
    logic [SIDE_W-1:0] side_prev;
    logic              ge;

    if (s == 0) begin : g_first
      assign vld_prev  = vld_in;
      assign rem_prev  = W'(num);
      assign quo_prev  = '0;
      assign den_prev  = den;
      assign side_prev = side_in;
    end else begin : g_next
      assign vld_prev  = vld[s-1];
      assign rem_prev  = rem[s-1];
      assign quo_prev  = quo_r[s-1];
      assign den_prev  = den_r[s-1];
      assign side_prev = side_r[s-1];
    end

    // trial subtract of the shifted divisor
    assign shifted  = W'(den_prev) << K;
    assign ge       = (rem_prev >= shifted);
    assign rem_next = ge ? rem_prev - shifted : rem_prev;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (en) begin
        vld[s] <= vld_prev;
      end
      if (en) begin
        quo_r[s]  <= quo_prev | (ge ? (Q_W'(1) << K) : '0);
        den_r[s]  <= den_prev;
        side_r[s] <= side_prev;
      end
    end

    if (s < Q_W - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem[s] <= rem_next;
        end
      end
    end
  end

  assign vld_out  = vld[Q_W-1];
  assign quo      = quo_r[Q_W-1];
  assign side_out = side_r[Q_W-1];

endmodule

`default_nettype wire

/* sv/pbr_back.sv */
// pbr_back: hue wrap, sector split and scaling back to rgb, ending in the output register
// depends on pbr_pkg
`timescale 1ns / 1ps
`default_nettype none

module pbr_back import pbr_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire logic             vld_in,
  input  wire logic [QUO_W-1:0] hue_q,
  input  wire logic [QUO_W-1:0] sat_q,
  input  wire logic [PCT_W-1:0] lvl,
  input  wire logic [PCT_W-1:0] vold,
  output logic                  vld_out,
  output logic [CH_W-1:0]       red,
  output logic [CH_W-1:0]       green,
  output logic [CH_W-1:0]       blue,
  output logic [HUE_W-1:0]      hue,
  output logic [PCT_W-1:0]      sat,
  output logic [PCT_W-1:0]      val
);

  localparam top_lut_t TOP_LUT = build_top_lut();

  // stage 1
  logic             b1_vld;
  logic [HUE_W-1:0] b1_h;
  logic [PCT_W-1:0] b1_s, b1_v;
  logic [CH_W-1:0]  b1_top;
  logic [14:0]      b1_pb;
  sector_t          b1_sec;
  // stage 2
  logic             b2_vld;
  logic [HUE_W-1:0] b2_h;
  logic [PCT_W-1:0] b2_s, b2_v;
  logic [CH_W-1:0]  b2_top, b2_bot;
  logic [5:0]       b2_frac;
  sector_t          b2_sec;
  // stage 3
  logic             b3_vld;
  logic [HUE_W-1:0] b3_h;
  logic [PCT_W-1:0] b3_s, b3_v;
  logic [CH_W-1:0]  b3_top, b3_bot;
  logic [13:0]      b3_pa;
  sector_t          b3_sec;
  // stage 4
  logic             b4_vld;
  logic [HUE_W-1:0] b4_h;
  logic [PCT_W-1:0] b4_s, b4_v;
  logic [CH_W-1:0]  b4_top, b4_bot, b4_adj;
  sector_t          b4_sec;

  logic [HUE_W-1:0] h1;
  logic [PCT_W-1:0] s1;
  logic [CH_W-1:0]  top1;
  logic [19:0]      ph;
  logic [27:0]      pbot;
  logic [30:0]      padj;
  logic [CH_W-1:0]  red_next, green_next, blue_next;

  // stage 1: wrap hue, full-scale lookup, products for min channel and sector
  assign h1   = (hue_q >= HUE_W'(CIRCLE_DEG)) ? hue_q - HUE_W'(CIRCLE_DEG) : hue_q;
  assign s1   = sat_q[PCT_W-1:0];
  assign top1 = TOP_LUT[lvl];
  assign ph   = 20'(h1) * 20'(1093);

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_vld <= 1'b0;
    end else if (en) begin
      b1_vld <= vld_in;
    end
    if (en) begin
      b1_h   <= h1;
      b1_s   <= s1;
      b1_v   <= vold;
      b1_top <= top1;
      b1_pb  <= 15'(top1) * 15'(PCT_W'(PCT_FULL) - s1);
      b1_sec <= sector_t'(ph[18:16]);
    end
  end

  // stage 2: min channel by reciprocal of 100, angle within sector
  assign pbot = 28'(b1_pb) * 28'(5243);

  always_ff @(posedge clk) begin
    if (rst) begin
      b2_vld <= 1'b0;
    end else if (en) begin
      b2_vld <= b1_vld;
    end
    if (en) begin
      b2_h    <= b1_h;
      b2_s    <= b1_s;
      b2_v    <= b1_v;
      b2_top  <= b1_top;
      b2_bot  <= pbot[26:19];
      b2_frac <= 6'(b1_h - HUE_W'(60) * HUE_W'(b1_sec));
      b2_sec  <= b1_sec;
    end
  end

  // stage 3: span times angle
  always_ff @(posedge clk) begin
    if (rst) begin
      b3_vld <= 1'b0;
    end else if (en) begin
      b3_vld <= b2_vld;
    end
    if (en) begin
      b3_h   <= b2_h;
      b3_s   <= b2_s;
      b3_v   <= b2_v;
      b3_top <= b2_top;
      b3_bot <= b2_bot;
      b3_pa  <= 14'(b2_top - b2_bot) * 14'(b2_frac);
      b3_sec <= b2_sec;
    end
  end

  // stage 4: divide by 60 through reciprocal
  assign padj = 31'(b3_pa) * 31'(69906);

  always_ff @(posedge clk) begin
    if (rst) begin
      b4_vld <= 1'b0;
    end else if (en) begin
      b4_vld <= b3_vld;
    end
    if (en) begin
      b4_h   <= b3_h;
      b4_s   <= b3_s;
      b4_v   <= b3_v;
      b4_top <= b3_top;
      b4_bot <= b3_bot;
      b4_adj <= padj[29:22];
      b4_sec <= b3_sec;
    end
  end

  // channel placement by sector
  always_comb begin
    case (b4_sec)
      SEC_RED_YEL: begin
        red_next = b4_top; green_next = b4_bot + b4_adj; blue_next = b4_bot;
      end
      SEC_YEL_GRN: begin
        red_next = b4_top - b4_adj; green_next = b4_top; blue_next = b4_bot;
      end
      SEC_GRN_CYN: begin
        red_next = b4_bot; green_next = b4_top; blue_next = b4_bot + b4_adj;
      end
      SEC_CYN_BLU: begin
        red_next = b4_bot; green_next = b4_top - b4_adj; blue_next = b4_top;
      end
      SEC_BLU_MAG: begin
        red_next = b4_bot + b4_adj; green_next = b4_bot; blue_next = b4_top;
      end
      default: begin
        red_next = b4_top; green_next = b4_bot; blue_next = b4_top - b4_adj;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_out <= 1'b0;
    end else if (en) begin
      vld_out <= b4_vld;
    end
    if (en) begin
      red   <= red_next;
      green <= green_next;
      blue  <= blue_next;
      hue   <= b4_h;
      sat   <= b4_s;
      val   <= b4_v;
    end
  end

endmodule

`default_nettype wire

/* sv/pixel_brightness_rescale_core.sv */
// pixel_brightness_rescale_core: usage
// One pixel (red_in, green_in, blue_in) and a brightness percent (new_level) arrive on
// pix_in; one result leaves on pix_out with the new rgb plus the hue, saturation and
// value of the input pixel. new_level above 100 is taken as 100.
// Both channels are valid/ready; a transfer happens when both are high.
// The pipeline is one operand stage, nine stages of the pipelined
// divider (one quotient bit per stage, set by the 9-bit hue quotient), four
// back-conversion stages and the output register.
// Throughput is one pixel per cycle while pix_out.ready is high.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// pix_in.ready drops; empty slots let new pixels in while pix_out.valid is low.
// Synchronous reset clears all valid bits; no result is shown after reset
// until a pixel has made its way through. There is no state between pixels.
// depends on pbr_pkg, pbr_if, pbr_front, pbr_div, pbr_back
`timescale 1ns / 1ps
`default_nettype none

module pixel_brightness_rescale_core import pbr_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  pbr_in_if.sink    pix_in,
  pbr_out_if.source pix_out
);

  logic             en;
  logic             f_vld;
  logic [NUM_W-1:0] sat_num, hue_num;
  logic [DEN_W-1:0] sat_den, hue_den;
  logic [PCT_W-1:0] f_vold, f_lvl, d_vold, d_lvl;
  logic             sat_vld, hue_vld, out_vld;
  logic [QUO_W-1:0] sat_q, hue_q;

  // pipeline advances unless a result is waiting and not taken
  assign en           = !out_vld || pix_out.ready;
  assign pix_in.ready = en;
  assign pix_out.valid = out_vld;

  pbr_front u_front (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .vld_in  (pix_in.valid),
    .red     (pix_in.red_in),
    .green   (pix_in.green_in),
    .blue    (pix_in.blue_in),
    .level   (pix_in.new_level),
    .vld     (f_vld),
    .sat_num (sat_num),
    .sat_den (sat_den),
    .hue_num (hue_num),
    .hue_den (hue_den),
    .vold    (f_vold),
    .lvl     (f_lvl)
  );

  pbr_div #(.N_W(NUM_W), .D_W(DEN_W), .Q_W(QUO_W), .SIDE_W(PCT_W)) u_sat_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .vld_in   (f_vld),
    .num      (sat_num),
    .den      (sat_den),
    .side_in  (f_lvl),
    .vld_out  (sat_vld),
    .quo      (sat_q),
    .side_out (d_lvl)
  );

  pbr_div #(.N_W(NUM_W), .D_W(DEN_W), .Q_W(QUO_W), .SIDE_W(PCT_W)) u_hue_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .vld_in   (f_vld),
    .num      (hue_num),
    .den      (hue_den),
    .side_in  (f_vold),
    .vld_out  (hue_vld),
    .quo      (hue_q),
    .side_out (d_vold)
  );

  pbr_back u_back (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .vld_in  (sat_vld && hue_vld),
    .hue_q   (hue_q),
    .sat_q   (sat_q),
    .lvl     (d_lvl),
    .vold    (d_vold),
    .vld_out (out_vld),
    .red     (pix_out.red_out),
    .green   (pix_out.green_out),
    .blue    (pix_out.blue_out),
    .hue     (pix_out.hue_deg),
    .sat     (pix_out.sat_pct),
    .val     (pix_out.old_level)
  );

endmodule

`default_nettype wire

/* sv/pbr_checker.sv */
// pbr_props: port-level checks on the pixel brightness rescale core, bound to the top
// depends on pbr_pkg and pixel_brightness_rescale_core
`timescale 1ns / 1ps
`default_nettype none

module pbr_props import pbr_pkg::*; (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             in_ready,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire logic [CH_W-1:0]  red_out,
  input wire logic [CH_W-1:0]  green_out,
  input wire logic [CH_W-1:0]  blue_out,
  input wire logic [HUE_W-1:0] hue_deg,
  input wire logic [PCT_W-1:0] sat_pct,
  input wire logic [PCT_W-1:0] old_level
);

  // a stalled result keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(red_out) && $stable(green_out)
      && $stable(blue_out) && $stable(hue_deg) && $stable(sat_pct) && $stable(old_level)))
    else $error("stalled result changed");

  // nothing shown right after reset
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // input only held off by a waiting result
  a_backpress: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without a waiting result");

  // reported hsv stays in range
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (hue_deg < HUE_W'(CIRCLE_DEG) && sat_pct <= PCT_W'(PCT_FULL)
      && old_level <= PCT_W'(PCT_FULL)))
    else $error("hsv out of range");

  // a grey input gives a grey output
  a_grey: assert property (@(posedge clk) disable iff (rst)
    (out_valid && sat_pct == '0) |-> (red_out == green_out && green_out == blue_out))
    else $error("grey pixel not grey");

endmodule

bind pixel_brightness_rescale_core pbr_props u_pbr_props (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (pix_in.ready),
  .out_valid (pix_out.valid),
  .out_ready (pix_out.ready),
  .red_out   (pix_out.red_out),
  .green_out (pix_out.green_out),
  .blue_out  (pix_out.blue_out),
  .hue_deg   (pix_out.hue_deg),
  .sat_pct   (pix_out.sat_pct),
  .old_level (pix_out.old_level)
);

`default_nettype wire

/* test/pbr_checker.sv */
// pbr_checker: watches the pixel channels, predicts each result and compares it
// depends on pbr_pkg and pbr_if (pbr_in_if, pbr_out_if)
`timescale 1ns / 1ps

module pbr_checker import pbr_pkg::*; (
  input  logic clk,
  input  logic rst,
  pbr_in_if  pix_in,
  pbr_out_if pix_out,
  output int unsigned fail_count,
  output int unsigned pending,
  output int unsigned seen_count
);

  typedef struct packed {
    logic [CH_W-1:0]  red;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  blue;
    logic [HUE_W-1:0] hue;
    logic [PCT_W-1:0] sat;
    logic [PCT_W-1:0] lvl;
  } hsv_result_t;

  hsv_result_t expected_q[$];

  function automatic int unsigned rdiv(int unsigned num, int unsigned den);
    return (2 * num + den) / (2 * den);
  endfunction

  // integer rgb -> hsv -> rgb with the brightness swapped
  function automatic hsv_result_t rescale_pixel(logic [7:0] r8, logic [7:0] g8,
                                                logic [7:0] b8, logic [6:0] l7);
    hsv_result_t res;
    int unsigned r, g, b, lv, mx, mn, d, hue, sat, top, bot, adj, frac;
    sector_t sec;
    r = 32'(r8); g = 32'(g8); b = 32'(b8); lv = 32'(l7);
    mx = r; if (g > mx) mx = g; if (b > mx) mx = b;
    mn = r; if (g < mn) mn = g; if (b < mn) mn = b;
    d = mx - mn;
    sat = (mx == 0) ? 0 : rdiv(100 * d, mx);
    // hue with red winning ties, then green
    if (d == 0) hue = 0;
    else if (r == mx) hue = (120 * g + 721 * d - 120 * b) / (2 * d);
    else if (g == mx) hue = (120 * b + 241 * d - 120 * r) / (2 * d);
    else hue = (120 * r + 481 * d - 120 * g) / (2 * d);
    if (hue >= CIRCLE_DEG) hue -= CIRCLE_DEG;
    if (lv > PCT_FULL) lv = PCT_FULL;
    top = lv * 255 / 100;
    bot = top * (100 - sat) / 100;
    frac = hue % 60;
    adj = (top - bot) * frac / 60;
    sec = sector_t'(hue / 60);
    case (sec)
      SEC_RED_YEL: begin
        res.red = CH_W'(top); res.green = CH_W'(bot + adj); res.blue = CH_W'(bot);
      end
      SEC_YEL_GRN: begin
        res.red = CH_W'(top - adj); res.green = CH_W'(top); res.blue = CH_W'(bot);
      end
      SEC_GRN_CYN: begin
        res.red = CH_W'(bot); res.green = CH_W'(top); res.blue = CH_W'(bot + adj);
      end
      SEC_CYN_BLU: begin
        res.red = CH_W'(bot); res.green = CH_W'(top - adj); res.blue = CH_W'(top);
      end
      SEC_BLU_MAG: begin
        res.red = CH_W'(bot + adj); res.green = CH_W'(bot); res.blue = CH_W'(top);
      end
      default: begin
        res.red = CH_W'(top); res.green = CH_W'(bot); res.blue = CH_W'(top - adj);
      end
    endcase
    res.hue = HUE_W'(hue);
    res.sat = PCT_W'(sat);
    res.lvl = PCT_W'(rdiv(100 * mx, 255));
    return res;
  endfunction

  assign pending = expected_q.size();

  // predict on input transfer, compare on output transfer
  always @(posedge clk) begin
    hsv_result_t exp_r;
    if (rst) begin
      fail_count <= 0;
      seen_count <= 0;
    end else begin
      if (pix_in.valid && pix_in.ready)
        expected_q.push_back(rescale_pixel(pix_in.red_in, pix_in.green_in,
                                           pix_in.blue_in, pix_in.new_level));
      if (pix_out.valid && pix_out.ready) begin
        seen_count <= seen_count + 1;
        if (expected_q.size() == 0) begin
          $error("result transfer with nothing expected");
          fail_count <= fail_count + 1;
        end else begin
          exp_r = expected_q.pop_front();
          if ({pix_out.red_out, pix_out.green_out, pix_out.blue_out, pix_out.hue_deg,
               pix_out.sat_pct, pix_out.old_level} !== exp_r)
            fail_count <= fail_count + 1;
          if (pix_out.red_out !== exp_r.red)
            $error("red_out expected %0d actual %0d", exp_r.red, pix_out.red_out);
          if (pix_out.green_out !== exp_r.green)
            $error("green_out expected %0d actual %0d", exp_r.green, pix_out.green_out);
          if (pix_out.blue_out !== exp_r.blue)
            $error("blue_out expected %0d actual %0d", exp_r.blue, pix_out.blue_out);
          if (pix_out.hue_deg !== exp_r.hue)
            $error("hue_deg expected %0d actual %0d", exp_r.hue, pix_out.hue_deg);
          if (pix_out.sat_pct !== exp_r.sat)
            $error("sat_pct expected %0d actual %0d", exp_r.sat, pix_out.sat_pct);
          if (pix_out.old_level !== exp_r.lvl)
            $error("old_level expected %0d actual %0d", exp_r.lvl, pix_out.old_level);
        end
      end
    end
  end

endmodule

/* test/pixel_brightness_rescale_core_tb.sv */
// pixel_brightness_rescale_core_tb: stimulus, receiver stalls and verdict
// depends on pbr_pkg, pbr_if, pbr_checker and the block itself
`timescale 1ns / 1ps

module pixel_brightness_rescale_core_tb;
  import pbr_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int unsigned fail_count, pending, seen_count;
  int unsigned sent = 0;
  logic long_hold = 1'b0;

  pbr_in_if  pix_in ();
  pbr_out_if pix_out ();

  pixel_brightness_rescale_core uut (.clk(clk), .rst(rst), .pix_in(pix_in), .pix_out(pix_out));
  pbr_checker chk (.clk(clk), .rst(rst), .pix_in(pix_in), .pix_out(pix_out),
                   .fail_count(fail_count), .pending(pending), .seen_count(seen_count));

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    pix_in.valid = 1'b0;
    pix_in.red_in = '0;
    pix_in.green_in = '0;
    pix_in.blue_in = '0;
    pix_in.new_level = '0;
    pix_out.ready = 1'b0;
  end

  // offer one pixel and hold it until the transfer
  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [6:0] l);
    pix_in.valid <= 1'b1;
    pix_in.red_in <= r;
    pix_in.green_in <= g;
    pix_in.blue_in <= b;
    pix_in.new_level <= l;
    do @(posedge clk); while (!pix_in.ready);
    sent++;
  endtask

  task automatic go_idle(int unsigned n);
    pix_in.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // receiver: stall pattern of its own, plus one long hold-off
  initial begin
    int unsigned mode;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (long_hold) pix_out.ready <= 1'b0;
      else begin
        mode = (sent / 100) % 4;
        case (mode)
          0: pix_out.ready <= 1'b1;
          1: pix_out.ready <= ($urandom_range(0, 3) != 0);
          2: pix_out.ready <= ($urandom_range(0, 1) != 0);
          default: pix_out.ready <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  initial begin
    int unsigned burst, k;
    logic [7:0] m;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed corners: black, white, greys, ties, primaries, negative red hue
    send_pixel(8'd0, 8'd0, 8'd0, 7'd0);
    send_pixel(8'd255, 8'd255, 8'd255, 7'd100);
    send_pixel(8'd128, 8'd128, 8'd128, 7'd127);
    send_pixel(8'd255, 8'd0, 8'd0, 7'd101);
    send_pixel(8'd0, 8'd255, 8'd0, 7'd50);
    send_pixel(8'd0, 8'd0, 8'd255, 7'd1);
    send_pixel(8'd255, 8'd255, 8'd0, 7'd99);
    send_pixel(8'd0, 8'd255, 8'd255, 7'd75);
    send_pixel(8'd255, 8'd0, 8'd255, 7'd25);
    send_pixel(8'd200, 8'd200, 8'd10, 7'd60);
    send_pixel(8'd200, 8'd10, 8'd200, 7'd60);
    send_pixel(8'd10, 8'd200, 8'd200, 7'd60);
    send_pixel(8'd255, 8'd0, 8'd1, 7'd100);
    send_pixel(8'd200, 8'd10, 8'd100, 7'd80);
    send_pixel(8'd1, 8'd0, 8'd0, 7'd64);
    send_pixel(8'd0, 8'd0, 8'd1, 7'd33);
    send_pixel(8'd170, 8'd85, 8'd85, 7'd127);
    send_pixel(8'd254, 8'd253, 8'd1, 7'd42);
    go_idle(1);

    // sender pauses until every expected result is back
    while (pending != 0) @(posedge clk);

    // long receiver hold-off while the sender keeps offering
    long_hold <= 1'b1;
    fork
      begin
        repeat (60) @(posedge clk);
        long_hold <= 1'b0;
      end
      for (k = 0; k < 30; k++)
        send_pixel($urandom, $urandom, $urandom, $urandom);
    join
    go_idle(2);

    // random bursts, half arbitrary pixels and the rest greys and ties
    while (sent < 720) begin
      burst = $urandom_range(1, 20);
      for (k = 0; k < burst; k++) begin
        m = $urandom;
        case ($urandom_range(0, 7))
          0: send_pixel(m, m, m, $urandom);
          1: send_pixel(m, m, $urandom, $urandom);
          2: send_pixel(m, $urandom, m, $urandom);
          3: send_pixel($urandom, m, m, $urandom_range(95, 127));
          default: send_pixel($urandom, $urandom, $urandom, $urandom);
        endcase
      end
      if ($urandom_range(0, 2) != 0) go_idle($urandom_range(1, 8));
    end
    go_idle(1);

    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    $display("pixels sent %0d, results checked %0d, incl. greys, ties and level saturation",
             sent, seen_count);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

/* files.f */
sv/pbr_pkg.sv
sv/pbr_if.sv
sv/pbr_front.sv
sv/pbr_div.sv
sv/pbr_back.sv
sv/pixel_brightness_rescale_core.sv
sv/pbr_checker.sv
test/pbr_checker.sv
test/pixel_brightness_rescale_core_tb.sv
